[rtl/bpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types for the barycentric point/triangle weight pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

   // control that travels beside each beat down the pipeline
   typedef struct packed {
      logic valid;
      logic neg_v;
      logic neg_w;
      logic degen;
   } bpt_ctl_type;

endpackage
`default_nettype wire

[rtl/bpt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_front
// Edge vectors, dot products, Gram determinant and the two numerators,
// six registered stages, ending in sign/magnitude form for the dividers.
// ----------------------------------------------------------------------------
module bpt_front import bpt_pkg::*; #(
   parameter int COORD_WIDTH  = 16,
   parameter int WEIGHT_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                valid_i,
   input  wire logic signed [COORD_WIDTH-1:0]       p_x,
   input  wire logic signed [COORD_WIDTH-1:0]       p_y,
   input  wire logic signed [COORD_WIDTH-1:0]       p_z,
   input  wire logic signed [COORD_WIDTH-1:0]       a_x,
   input  wire logic signed [COORD_WIDTH-1:0]       a_y,
   input  wire logic signed [COORD_WIDTH-1:0]       a_z,
   input  wire logic signed [COORD_WIDTH-1:0]       b_x,
   input  wire logic signed [COORD_WIDTH-1:0]       b_y,
   input  wire logic signed [COORD_WIDTH-1:0]       b_z,
   input  wire logic signed [COORD_WIDTH-1:0]       c_x,
   input  wire logic signed [COORD_WIDTH-1:0]       c_y,
   input  wire logic signed [COORD_WIDTH-1:0]       c_z,
   output bpt_ctl_type                              ctl_o,
   output logic [2*(2*COORD_WIDTH+4)-0:0]           div_o,
   output logic [2*(2*COORD_WIDTH+4)+WEIGHT_WIDTH-2:0] num_v_o,
   output logic [2*(2*COORD_WIDTH+4)+WEIGHT_WIDTH-2:0] num_w_o
);
   localparam int EW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * EW;
   localparam int DW   = PW + 2;
   localparam int GW   = 2 * DW + 1;
   localparam int FRAC = WEIGHT_WIDTH - 2;
   localparam int NW   = GW + FRAC;

   logic [4:0] vld_ff;

   logic signed [EW-1:0] e0_ff [3];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];

   logic signed [PW-1:0] pr00_ff [3];
   logic signed [PW-1:0] pr01_ff [3];
   logic signed [PW-1:0] pr11_ff [3];
   logic signed [PW-1:0] pr20_ff [3];
   logic signed [PW-1:0] pr21_ff [3];

   logic signed [DW-1:0] d00_ff, d01_ff, d11_ff, d20_ff, d21_ff;
   logic signed [2*DW-1:0] m_ff [6];
   logic signed [GW-1:0] det_ff, nv_ff, nw_ff;

   bpt_ctl_type   ctl_ff;
   logic [GW-1:0] div_ff;
   logic [NW-1:0] num_v_ff, num_w_ff;

   logic signed [EW-1:0] pc [3], ac [3], bc [3], cc [3];

   always_comb begin
      pc[0] = EW'(p_x); pc[1] = EW'(p_y); pc[2] = EW'(p_z);
      ac[0] = EW'(a_x); ac[1] = EW'(a_y); ac[2] = EW'(a_z);
      bc[0] = EW'(b_x); bc[1] = EW'(b_y); bc[2] = EW'(b_z);
      cc[0] = EW'(c_x); cc[1] = EW'(c_y); cc[2] = EW'(c_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[3:0], valid_i};
         ctl_ff.valid <= vld_ff[4];
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            e0_ff[k]   <= bc[k] - ac[k];
            e1_ff[k]   <= cc[k] - ac[k];
            e2_ff[k]   <= pc[k] - ac[k];
            pr00_ff[k] <= e0_ff[k] * e0_ff[k];
            pr01_ff[k] <= e0_ff[k] * e1_ff[k];
            pr11_ff[k] <= e1_ff[k] * e1_ff[k];
            pr20_ff[k] <= e2_ff[k] * e0_ff[k];
            pr21_ff[k] <= e2_ff[k] * e1_ff[k];
         end
         d00_ff <= DW'(pr00_ff[0]) + DW'(pr00_ff[1]) + DW'(pr00_ff[2]);
         d01_ff <= DW'(pr01_ff[0]) + DW'(pr01_ff[1]) + DW'(pr01_ff[2]);
         d11_ff <= DW'(pr11_ff[0]) + DW'(pr11_ff[1]) + DW'(pr11_ff[2]);
         d20_ff <= DW'(pr20_ff[0]) + DW'(pr20_ff[1]) + DW'(pr20_ff[2]);
         d21_ff <= DW'(pr21_ff[0]) + DW'(pr21_ff[1]) + DW'(pr21_ff[2]);
         m_ff[0] <= d00_ff * d11_ff;
         m_ff[1] <= d01_ff * d01_ff;
         m_ff[2] <= d11_ff * d20_ff;
         m_ff[3] <= d01_ff * d21_ff;
         m_ff[4] <= d00_ff * d21_ff;
         m_ff[5] <= d01_ff * d20_ff;
         det_ff <= GW'(m_ff[0]) - GW'(m_ff[1]);
         nv_ff  <= GW'(m_ff[2]) - GW'(m_ff[3]);
         nw_ff  <= GW'(m_ff[4]) - GW'(m_ff[5]);
         // sign and magnitude for the unsigned divider cells
         ctl_ff.neg_v <= nv_ff[GW-1] ^ det_ff[GW-1];
         ctl_ff.neg_w <= nw_ff[GW-1] ^ det_ff[GW-1];
         ctl_ff.degen <= (det_ff == '0);
         div_ff   <= det_ff[GW-1] ? GW'(-det_ff) : GW'(det_ff);
         num_v_ff <= {(nv_ff[GW-1] ? GW'(-nv_ff) : GW'(nv_ff)), {FRAC{1'b0}}};
         num_w_ff <= {(nw_ff[GW-1] ? GW'(-nw_ff) : GW'(nw_ff)), {FRAC{1'b0}}};
      end
   end

   assign ctl_o   = ctl_ff;
   assign div_o   = div_ff;
   assign num_v_o = num_v_ff;
   assign num_w_o = num_w_ff;

endmodule
`default_nettype wire

[rtl/bpt_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_div_cell
// One restoring division step for both weight lanes: one quotient bit per
// lane, then the partial remainder and quotient pass to the next cell.
// ----------------------------------------------------------------------------
module bpt_div_cell import bpt_pkg::*; #(
   parameter int GW = 73,
   parameter int NW = 103
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire bpt_ctl_type   ctl_i,
   input  wire logic [GW-1:0] div_i,
   input  wire logic [GW-1:0] rem_v_i,
   input  wire logic [NW-1:0] nq_v_i,
   input  wire logic [GW-1:0] rem_w_i,
   input  wire logic [NW-1:0] nq_w_i,
   output bpt_ctl_type        ctl_o,
   output logic [GW-1:0]      div_o,
   output logic [GW-1:0]      rem_v_o,
   output logic [NW-1:0]      nq_v_o,
   output logic [GW-1:0]      rem_w_o,
   output logic [NW-1:0]      nq_w_o
);
   bpt_ctl_type   ctl_ff;
   logic [GW-1:0] div_ff, rem_v_ff, rem_w_ff;
   logic [NW-1:0] nq_v_ff, nq_w_ff;

   logic [GW:0]   trial_v, trial_w, diff_v, diff_w;
   logic          take_v, take_w;
   logic [GW-1:0] rem_v_in, rem_w_in;
   logic [NW-1:0] nq_v_in, nq_w_in;

   always_comb begin
      trial_v  = {rem_v_i, nq_v_i[NW-1]};
      trial_w  = {rem_w_i, nq_w_i[NW-1]};
      diff_v   = trial_v - {1'b0, div_i};
      diff_w   = trial_w - {1'b0, div_i};
      take_v   = (trial_v >= {1'b0, div_i});
      take_w   = (trial_w >= {1'b0, div_i});
      rem_v_in = take_v ? diff_v[GW-1:0] : trial_v[GW-1:0];
      rem_w_in = take_w ? diff_w[GW-1:0] : trial_w[GW-1:0];
      nq_v_in  = {nq_v_i[NW-2:0], take_v};
      nq_w_in  = {nq_w_i[NW-2:0], take_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (en) begin
         ctl_ff.neg_v <= ctl_i.neg_v;
         ctl_ff.neg_w <= ctl_i.neg_w;
         ctl_ff.degen <= ctl_i.degen;
         div_ff       <= div_i;
         rem_v_ff     <= rem_v_in;
         rem_w_ff     <= rem_w_in;
         nq_v_ff      <= nq_v_in;
         nq_w_ff      <= nq_w_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign div_o   = div_ff;
   assign rem_v_o = rem_v_ff;
   assign rem_w_o = rem_w_ff;
   assign nq_v_o  = nq_v_ff;
   assign nq_w_o  = nq_w_ff;

endmodule
`default_nettype wire

[rtl/bpt_finish.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_finish
// Restores quotient signs, forms u, saturates all weights, or zeroes them
// for a degenerate beat, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module bpt_finish import bpt_pkg::*; #(
   parameter int NW           = 103,
   parameter int WEIGHT_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire bpt_ctl_type              ctl_i,
   input  wire logic [NW-1:0]            q_v_i,
   input  wire logic [NW-1:0]            q_w_i,
   output logic                          valid_o,
   output logic signed [WEIGHT_WIDTH-1:0] weight_u,
   output logic signed [WEIGHT_WIDTH-1:0] weight_v,
   output logic signed [WEIGHT_WIDTH-1:0] weight_w,
   output logic                          degenerate
);
   localparam int WW   = WEIGHT_WIDTH;
   localparam int XW   = NW + 3;
   localparam int FRAC = WW - 2;

   function automatic logic signed [WW-1:0] sat(input logic signed [XW-1:0] x);
      logic signed [XW-1:0] hi_c;
      hi_c = x >>> (WW - 1);
      if (hi_c == '0 || hi_c == '1) begin
         return x[WW-1:0];
      end else if (x[XW-1]) begin
         return {1'b1, {(WW-1){1'b0}}};
      end else begin
         return {1'b0, {(WW-1){1'b1}}};
      end
   endfunction

   logic signed [XW-1:0] sv, sw, su, one_c;
   logic                 valid_ff, degen_ff;
   logic signed [WW-1:0] u_ff, v_ff, w_ff;

   always_comb begin
      one_c = XW'(1) <<< FRAC;
      sv = ctl_i.neg_v ? -$signed({3'b000, q_v_i}) : $signed({3'b000, q_v_i});
      sw = ctl_i.neg_w ? -$signed({3'b000, q_w_i}) : $signed({3'b000, q_w_i});
      su = one_c - sv - sw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= ctl_i.degen;
         u_ff     <= ctl_i.degen ? '0 : sat(su);
         v_ff     <= ctl_i.degen ? '0 : sat(sv);
         w_ff     <= ctl_i.degen ? '0 : sat(sw);
      end
   end

   assign valid_o    = valid_ff;
   assign degenerate = degen_ff;
   assign weight_u   = u_ff;
   assign weight_v   = v_ff;
   assign weight_w   = w_ff;

endmodule
`default_nettype wire

[rtl/barycentric_point_triangle_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_point_triangle_unit
// Barycentric weights of a point against a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// A request beat carries point p and corners a, b, c (signed Q8.8); the
// response beat carries weights u, v, w (signed Q2.30, saturated) and the
// degenerate flag, raised with all weights zero when the Gram determinant
// is zero.
// One beat is accepted every cycle while the pipeline is not stalled. The
// quotient width is NW = 2*(2*COORD_WIDTH+4) + 1 + WEIGHT_WIDTH - 2; each
// beat passes six front stages (edges, products, dots, cross products, det
// and numerators, sign/magnitude), one restoring division cell per quotient
// bit, then the output register. The whole pipeline advances together;
// when the receiver holds off a waiting response beat, every stage and
// req_ready stall with it.
// Reset empties the pipeline; beats in flight at reset are dropped.
// ----------------------------------------------------------------------------
module barycentric_point_triangle_unit import bpt_pkg::*; #(
   parameter int COORD_WIDTH  = 16,
   parameter int WEIGHT_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]  req_p_x,
   input  wire logic signed [COORD_WIDTH-1:0]  req_p_y,
   input  wire logic signed [COORD_WIDTH-1:0]  req_p_z,
   input  wire logic signed [COORD_WIDTH-1:0]  req_a_x,
   input  wire logic signed [COORD_WIDTH-1:0]  req_a_y,
   input  wire logic signed [COORD_WIDTH-1:0]  req_a_z,
   input  wire logic signed [COORD_WIDTH-1:0]  req_b_x,
   input  wire logic signed [COORD_WIDTH-1:0]  req_b_y,
   input  wire logic signed [COORD_WIDTH-1:0]  req_b_z,
   input  wire logic signed [COORD_WIDTH-1:0]  req_c_x,
   input  wire logic signed [COORD_WIDTH-1:0]  req_c_y,
   input  wire logic signed [COORD_WIDTH-1:0]  req_c_z,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [WEIGHT_WIDTH-1:0]      rsp_weight_u,
   output logic signed [WEIGHT_WIDTH-1:0]      rsp_weight_v,
   output logic signed [WEIGHT_WIDTH-1:0]      rsp_weight_w,
   output logic                                rsp_degenerate
);
   localparam int DW   = 2 * (COORD_WIDTH + 1) + 2;
   localparam int GW   = 2 * DW + 1;
   localparam int NW   = GW + WEIGHT_WIDTH - 2;

   logic en;

   bpt_ctl_type   ctl_c   [NW+1];
   logic [GW-1:0] div_c   [NW+1];
   logic [GW-1:0] rem_v_c [NW+1];
   logic [GW-1:0] rem_w_c [NW+1];
   logic [NW-1:0] nq_v_c  [NW+1];
   logic [NW-1:0] nq_w_c  [NW+1];

   // one global advance: a beat moves whenever the output slot frees
   assign en        = rsp_ready || !rsp_valid;
   assign req_ready = en;

   bpt_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .WEIGHT_WIDTH (WEIGHT_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (req_valid),
      .p_x     (req_p_x),
      .p_y     (req_p_y),
      .p_z     (req_p_z),
      .a_x     (req_a_x),
      .a_y     (req_a_y),
      .a_z     (req_a_z),
      .b_x     (req_b_x),
      .b_y     (req_b_y),
      .b_z     (req_b_z),
      .c_x     (req_c_x),
      .c_y     (req_c_y),
      .c_z     (req_c_z),
      .ctl_o   (ctl_c[0]),
      .div_o   (div_c[0]),
      .num_v_o (nq_v_c[0]),
      .num_w_o (nq_w_c[0])
   );

   assign rem_v_c[0] = '0;
   assign rem_w_c[0] = '0;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      bpt_div_cell #(
         .GW (GW),
         .NW (NW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_i   (ctl_c[i]),
         .div_i   (div_c[i]),
         .rem_v_i (rem_v_c[i]),
         .nq_v_i  (nq_v_c[i]),
         .rem_w_i (rem_w_c[i]),
         .nq_w_i  (nq_w_c[i]),
         .ctl_o   (ctl_c[i+1]),
         .div_o   (div_c[i+1]),
         .rem_v_o (rem_v_c[i+1]),
         .nq_v_o  (nq_v_c[i+1]),
         .rem_w_o (rem_w_c[i+1]),
         .nq_w_o  (nq_w_c[i+1])
      );
   end

   bpt_finish #(
      .NW           (NW),
      .WEIGHT_WIDTH (WEIGHT_WIDTH)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .ctl_i      (ctl_c[NW]),
      .q_v_i      (nq_v_c[NW]),
      .q_w_i      (nq_w_c[NW]),
      .valid_o    (rsp_valid),
      .weight_u   (rsp_weight_u),
      .weight_v   (rsp_weight_v),
      .weight_w   (rsp_weight_w),
      .degenerate (rsp_degenerate)
   );

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_weight_u == '0 && rsp_weight_v == '0 && rsp_weight_w == '0)
      else $error("degenerate beat with non-zero weights");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid && !ctl_c[0].valid)
      else $error("pipeline not empty after reset");

   a_stall_holds_chain : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ctl_c[NW].valid) && $stable(nq_v_c[NW]))
      else $error("division chain moved during a stall");

endmodule
`default_nettype wire

[sim/barycentric_point_triangle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_point_triangle_checker
// Watches both channels of the barycentric unit, predicts each response beat
// from the accepted request beat and compares the two field by field.
// ----------------------------------------------------------------------------
module barycentric_point_triangle_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_p_x,
   input  wire logic signed [15:0] req_p_y,
   input  wire logic signed [15:0] req_p_z,
   input  wire logic signed [15:0] req_a_x,
   input  wire logic signed [15:0] req_a_y,
   input  wire logic signed [15:0] req_a_z,
   input  wire logic signed [15:0] req_b_x,
   input  wire logic signed [15:0] req_b_y,
   input  wire logic signed [15:0] req_b_z,
   input  wire logic signed [15:0] req_c_x,
   input  wire logic signed [15:0] req_c_y,
   input  wire logic signed [15:0] req_c_z,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_weight_u,
   input  wire logic signed [31:0] rsp_weight_v,
   input  wire logic signed [31:0] rsp_weight_w,
   input  wire logic               rsp_degenerate,
   output int                      fail_count,
   output int                      weights_pending
);

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] w;
      logic               degenerate;
   } weight_set_type;

   weight_set_type expected_weights[$];

   function automatic logic signed [31:0] clamp_weight(input wide_type q);
      if (q > wide_type'(32'sh7fffffff)) return 32'sh7fffffff;
      if (q < -wide_type'(64'sh80000000)) return 32'sh80000000;
      return q[31:0];
   endfunction

   function automatic wide_type dot3(input wide_type x0, x1, x2, y0, y1, y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
   endfunction

   // pts holds p, a, b, c, each as x, y, z, lowest slice first
   function automatic weight_set_type barycentric_weights(input logic [191:0] pts);
      wide_type e0[3], e1[3], e2[3];
      wide_type corner, d00, d01, d11, d20, d21, det, qv, qw, qu;
      weight_set_type r;
      for (int k = 0; k < 3; k++) begin
         corner = $signed(pts[(3 + k) * 16 +: 16]);
         e0[k] = wide_type'($signed(pts[(6 + k) * 16 +: 16])) - corner;
         e1[k] = wide_type'($signed(pts[(9 + k) * 16 +: 16])) - corner;
         e2[k] = wide_type'($signed(pts[k * 16 +: 16])) - corner;
      end
      d00 = dot3(e0[0], e0[1], e0[2], e0[0], e0[1], e0[2]);
      d01 = dot3(e0[0], e0[1], e0[2], e1[0], e1[1], e1[2]);
      d11 = dot3(e1[0], e1[1], e1[2], e1[0], e1[1], e1[2]);
      d20 = dot3(e2[0], e2[1], e2[2], e0[0], e0[1], e0[2]);
      d21 = dot3(e2[0], e2[1], e2[2], e1[0], e1[1], e1[2]);
      det = d00 * d11 - d01 * d01;
      if (det == 0) begin
         r = '{u: '0, v: '0, w: '0, degenerate: 1'b1};
         return r;
      end
      // signed division truncates toward zero
      qv = ((d11 * d20 - d01 * d21) <<< 30) / det;
      qw = ((d00 * d21 - d01 * d20) <<< 30) / det;
      qu = (wide_type'(1) <<< 30) - qv - qw;
      r.u = clamp_weight(qu);
      r.v = clamp_weight(qv);
      r.w = clamp_weight(qw);
      r.degenerate = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      weights_pending = 0;
   end

   always @(posedge clock) begin
      weight_set_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_weights.push_back(barycentric_weights({
               req_c_z, req_c_y, req_c_x, req_b_z, req_b_y, req_b_x,
               req_a_z, req_a_y, req_a_x, req_p_z, req_p_y, req_p_x}));
         if (rsp_valid && rsp_ready) begin
            if (expected_weights.size() == 0) begin
               report_mismatch("unexpected response beat", 32'd1, 32'd0);
            end else begin
               want = expected_weights.pop_front();
               if (rsp_weight_u !== want.u) report_mismatch("weight_u", rsp_weight_u, want.u);
               if (rsp_weight_v !== want.v) report_mismatch("weight_v", rsp_weight_v, want.v);
               if (rsp_weight_w !== want.w) report_mismatch("weight_w", rsp_weight_w, want.w);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, want.degenerate);
            end
         end
      end
      weights_pending = expected_weights.size();
   end

endmodule

[sim/barycentric_point_triangle_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_point_triangle_unit_test
// Drives request beats into the barycentric unit with random gaps and
// response back-pressure, including one long hold-off that fills the
// pipeline; the checker alongside predicts and compares every beat.
// ----------------------------------------------------------------------------
module barycentric_point_triangle_unit_test;

   localparam int RANDOM_BEATS = 1900;
   localparam int STALL_LIMIT  = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_p_x, req_p_y, req_p_z;
   logic signed [15:0] req_a_x, req_a_y, req_a_z;
   logic signed [15:0] req_b_x, req_b_y, req_b_z;
   logic signed [15:0] req_c_x, req_c_y, req_c_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_weight_u, rsp_weight_v, rsp_weight_w;
   logic               rsp_degenerate;
   int                 fail_count;
   int                 weights_pending;

   // coordinates of the next beat: p, a, b, c, each x, y, z
   logic signed [15:0] pts[12];
   int                 beats_sent;
   int                 idle_odds;
   int                 stall_cycles;

   barycentric_point_triangle_unit i_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_p_x, .req_p_y, .req_p_z, .req_a_x, .req_a_y, .req_a_z,
      .req_b_x, .req_b_y, .req_b_z, .req_c_x, .req_c_y, .req_c_z,
      .rsp_valid, .rsp_ready, .rsp_weight_u, .rsp_weight_v, .rsp_weight_w,
      .rsp_degenerate
   );

   barycentric_point_triangle_checker i_checker (
      .clock, .reset, .req_valid, .req_ready,
      .req_p_x, .req_p_y, .req_p_z, .req_a_x, .req_a_y, .req_a_z,
      .req_b_x, .req_b_y, .req_b_z, .req_c_x, .req_c_y, .req_c_z,
      .rsp_valid, .rsp_ready, .rsp_weight_u, .rsp_weight_v, .rsp_weight_w,
      .rsp_degenerate, .fail_count, .weights_pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 99) >= idle_odds) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_beat();
      int gap;
      req_valid <= 1'b1;
      {req_p_x, req_p_y, req_p_z} <= {pts[0], pts[1], pts[2]};
      {req_a_x, req_a_y, req_a_z} <= {pts[3], pts[4], pts[5]};
      {req_b_x, req_b_y, req_b_z} <= {pts[6], pts[7], pts[8]};
      {req_c_x, req_c_y, req_c_z} <= {pts[9], pts[10], pts[11]};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_triangle(input logic signed [15:0] p, a, b, c);
      // same value on all three axes keeps the directed cases readable
      for (int k = 0; k < 3; k++) begin
         pts[k] = p; pts[3 + k] = a; pts[6 + k] = b; pts[9 + k] = c;
      end
   endtask

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(0, 9))
         6, 7:    return 16'($signed($urandom_range(0, 2047)) - 1024);
         8:       case ($urandom_range(0, 3))
                     0: return 16'sh8000;
                     1: return 16'sh7fff;
                     2: return 16'sh0000;
                     default: return -16'sd1;
                  endcase
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_triangle();
      logic signed [15:0] step;
      for (int k = 0; k < 12; k++) pts[k] = random_coord();
      case ($urandom_range(0, 9))
         // collinear corners
         6: for (int k = 0; k < 3; k++) begin
               step = 16'($signed($urandom_range(0, 128)) - 64);
               pts[3 + k] = 16'($signed($urandom_range(0, 2000)) - 1000);
               pts[6 + k] = pts[3 + k] + step;
               pts[9 + k] = 16'(pts[3 + k] + 2 * step);
            end
         // coincident corners
         7: for (int k = 0; k < 3; k++) pts[6 + k] = pts[3 + k];
         // tiny triangle with a distant point, drives weights into saturation
         8: for (int k = 0; k < 3; k++) begin
               pts[6 + k] = pts[3 + k] + 16'($urandom_range(0, 3));
               pts[9 + k] = pts[3 + k] - 16'($urandom_range(0, 3));
            end
         // flat triangle in z with a small well-formed layout
         9: for (int k = 0; k < 12; k++)
               pts[k] = (k % 3 == 2) ? 16'sd0
                                     : 16'($signed($urandom_range(0, 1023)) - 512);
         default: ;
      endcase
   endtask

   // receiver: random hold-offs plus one long hold-off
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (beats_sent >= 300 && stall_cycles == 0) begin
            rsp_ready <= 1'b0;
            while (stall_cycles < 400) begin
               @(posedge clock);
               stall_cycles++;
            end
         end
         gap = gap_length();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else if (!reset) quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("barycentric_point_triangle_unit test failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_p_x, req_p_y, req_p_z, req_a_x, req_a_y, req_a_z} = '0;
      {req_b_x, req_b_y, req_b_z, req_c_x, req_c_y, req_c_z} = '0;
      beats_sent = 0;
      stall_cycles = 0;
      idle_odds = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, unit triangle corners, outside, extremes
      set_triangle(0, 0, 0, 0); send_beat();
      pts = '{0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0}; send_beat();
      pts = '{256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0}; send_beat();
      pts = '{0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0}; send_beat();
      pts = '{85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0}; send_beat();
      pts = '{-512, 700, 9, 0, 0, 0, 256, 0, 0, 0, 256, 0}; send_beat();
      pts = '{32767, -32768, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 0}; send_beat();
      pts = '{-32768, 32767, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}; send_beat();
      pts = '{0, 0, 0, -32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, 32767}; send_beat();
      pts = '{32767, 32767, 32767, 32767, -32768, 0, -32768, 32767, 0,
              -32768, -32768, 32767}; send_beat();
      pts = '{-1, -1, -1, 32767, 32767, 32767, -32768, -32768, -32768,
              0, 32767, -32768}; send_beat();
      set_triangle(-32768, -32768, 32767, 32767); send_beat();
      set_triangle(5, 1, 2, 3); send_beat();
      pts = '{0, 0, 0, 100, 100, 100, 100, 100, 100, 0, 0, 0}; send_beat();
      pts = '{0, 0, 0, 10, 20, 30, 20, 40, 60, 30, 60, 90}; send_beat();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // phases alternate between no idling and light or heavy idling
         if (n % 200 == 0) idle_odds = (n % 600 == 0) ? 0 : $urandom_range(10, 60);
         random_triangle();
         send_beat();
      end
      req_valid <= 1'b0;
      while (weights_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("barycentric_point_triangle_unit test passed");
      end else begin
         $display("barycentric_point_triangle_unit test failed");
      end
      $finish;
   end

endmodule
